FILE: rtl/cpj_pkg.sv
// Shared types and constants for the two-dimensional Chebyshev projection core.
// Used by cpj_ctrl, cpj_dp and chebyshev_2d_projection_core.
package cpj_pkg;

  localparam int MAX_NODES   = 128;
  localparam int DEGREE      = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int DEG_W       = 5;
  localparam int SAMPLE_W    = 16;
  localparam int PART_W      = 40;
  localparam int PROD_W      = PART_W + SAMPLE_W;
  localparam int ACC_W       = PROD_W + NODE_W;
  localparam int SCALE_W     = 25;
  localparam int COEF_W      = 32;
  localparam int NCOUNT_W    = 8;
  localparam int BASIS_DEPTH = (DEGREE + 1) * MAX_NODES;
  localparam int BASIS_AW    = $clog2(BASIS_DEPTH);
  localparam int GRID_AW     = 2 * NODE_W;

  localparam logic [1:0] KIND_BASIS   = 2'd0;
  localparam logic [1:0] KIND_GRID    = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_COEF_SCALE = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              phase2;
    logic              first;
    logic              last;
    logic              zero;
    logic              n0;
    logic              m0;
    logic              last_row;
    logic [DEG_W-1:0]  deg_n;
    logic [DEG_W-1:0]  deg_m;
    logic [DEG_W-1:0]  basis_row;
    logic [NODE_W-1:0] basis_col;
    logic [NODE_W-1:0] grid_row;
    logic [NODE_W-1:0] grid_col;
  } cpj_cmd_t;

endpackage

FILE: rtl/cpj_ctrl.sv
// Sequencer for the projection core: walks both sum phases and the degree row.
// Depends on cpj_pkg; drives the command word consumed by cpj_dp.
module cpj_ctrl import cpj_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          kind,
  input  logic [NODE_W-1:0]   row_index,
  input  logic [NCOUNT_W-1:0] nodes,
  input  logic                result_valid,
  output logic                busy,
  output cpj_cmd_t            cmd
);

  typedef enum logic [2:0] {IDLE, PHASE1, DRAIN, PHASE2, WAIT_RES} state_t;

  state_t            state;
  logic [NODE_W-1:0] i, j, nm1;
  logic [DEG_W-1:0]  n, m;
  logic              nzero;
  logic [1:0]        cnt;
  logic [DEG_W-1:0]  last_m;

  assign busy   = (state != IDLE);
  assign last_m = DEG_W'(DEGREE) - n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cmd   <= '0;
    end else begin
      cmd.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start && kind == KIND_COMPUTE && row_index <= NODE_W'(DEGREE)) begin
            n     <= row_index[DEG_W-1:0];
            nm1   <= NODE_W'(nodes - 1'b1);
            nzero <= (nodes == '0);
            i     <= '0;
            j     <= '0;
            m     <= '0;
            state <= (nodes == '0) ? PHASE2 : PHASE1;
          end
        end
        PHASE1: begin
          cmd.valid     <= 1'b1;
          cmd.phase2    <= 1'b0;
          cmd.first     <= (i == '0);
          cmd.last      <= (i == nm1);
          cmd.zero      <= 1'b0;
          cmd.basis_row <= n;
          cmd.basis_col <= i;
          cmd.grid_row  <= i;
          cmd.grid_col  <= j;
          if (i == nm1) begin
            i <= '0;
            if (j == nm1) begin
              j     <= '0;
              cnt   <= 2'd3;
              state <= DRAIN;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            i <= i + 1'b1;
          end
        end
        DRAIN: begin
          if (cnt == '0) begin
            state <= PHASE2;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        PHASE2: begin
          cmd.valid     <= 1'b1;
          cmd.phase2    <= 1'b1;
          cmd.first     <= (j == '0);
          cmd.last      <= nzero || (j == nm1);
          cmd.zero      <= nzero;
          cmd.n0        <= (n == '0);
          cmd.m0        <= (m == '0);
          cmd.last_row  <= (m == last_m);
          cmd.deg_n     <= n;
          cmd.deg_m     <= m;
          cmd.basis_row <= m;
          cmd.basis_col <= j;
          cmd.grid_row  <= j;
          cmd.grid_col  <= j;
          if (nzero || j == nm1) begin
            j     <= '0;
            state <= WAIT_RES;
          end else begin
            j <= j + 1'b1;
          end
        end
        WAIT_RES: begin
          if (result_valid) begin
            if (m == last_m) begin
              state <= IDLE;
            end else begin
              m     <= m + 1'b1;
              state <= PHASE2;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/cpj_dp.sv
// Datapath of the projection core: basis, grid and partial-row memories,
// the multiply-accumulate pipe and the scale, round and saturate unit. Uses cpj_pkg.
module cpj_dp import cpj_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [1:0]                 kind,
  input  logic [NODE_W-1:0]          row_index,
  input  logic [NODE_W-1:0]          col_index,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic [SCALE_W-1:0]         coef_scale,
  input  cpj_cmd_t                   cmd,
  output logic                       result_valid,
  output logic [DEG_W-1:0]           degree_x,
  output logic [DEG_W-1:0]           degree_y,
  output logic signed [COEF_W-1:0]   coefficient,
  output logic                       saturated,
  output logic                       last
);

  logic signed [SAMPLE_W-1:0] basis_mem [0:BASIS_DEPTH-1];
  logic signed [SAMPLE_W-1:0] grid_mem  [0:(1<<GRID_AW)-1];
  logic signed [PART_W-1:0]   part_mem  [0:MAX_NODES-1];

  logic signed [SAMPLE_W-1:0] basis_rd, grid_rd;
  logic signed [PART_W-1:0]   part_rd, opa;
  logic signed [PROD_W-1:0]   prod, mul;
  logic signed [ACC_W-1:0]    acc, acc_sum, fin_acc;
  cpj_cmd_t                   s1, s2, tag;
  logic                       fa_v, fb_v, fc_v;
  logic [ACC_W-1:0]           mag;
  logic [COEF_W+SCALE_W-1:0]  plo;
  logic [PROD_W-1:0]          phi;
  logic [COEF_W+SCALE_W-1:0]  t_sum, q;
  logic [1:0]                 sel;
  logic                       neg;

  always_ff @(posedge clk) begin
    if (load && kind == KIND_BASIS && row_index <= NODE_W'(DEGREE)) begin
      basis_mem[BASIS_AW'({row_index[DEG_W-1:0], col_index})] <= sample_value;
    end
    basis_rd <= basis_mem[BASIS_AW'({cmd.basis_row, cmd.basis_col})];
  end

  always_ff @(posedge clk) begin
    if (load && kind == KIND_GRID) begin
      grid_mem[{row_index, col_index}] <= sample_value;
    end
    grid_rd <= grid_mem[{cmd.grid_row, cmd.grid_col}];
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2.last && !s2.phase2) begin
      part_mem[s2.grid_col] <= acc_sum[PART_W-1:0];
    end
    part_rd <= part_mem[cmd.grid_col];
  end

  assign opa     = s1.phase2 ? part_rd : PART_W'(grid_rd);
  assign mul     = opa * basis_rd;
  assign acc_sum = (s2.first ? '0 : acc) + ACC_W'(prod);
  assign sel     = 2'(tag.n0) + 2'(tag.m0);
  assign t_sum   = (COEF_W+SCALE_W)'(phi) + (COEF_W+SCALE_W)'(plo[COEF_W+SCALE_W-1:COEF_W])
                 + ((COEF_W+SCALE_W)'(1) << (5'd16 + 5'(sel)));
  assign q       = t_sum >> (5'd17 + 5'(sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1           <= '0;
      s2           <= '0;
      fa_v         <= 1'b0;
      fb_v         <= 1'b0;
      fc_v         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s1           <= cmd;
      s2           <= s1;
      fa_v         <= s2.valid && s2.last && s2.phase2;
      fb_v         <= fa_v;
      fc_v         <= fb_v;
      result_valid <= fc_v;
    end
    prod <= s1.zero ? '0 : mul;
    if (s2.valid) begin
      acc <= acc_sum;
    end
    if (s2.valid && s2.last && s2.phase2) begin
      fin_acc <= acc_sum;
      tag     <= s2;
    end
    if (fa_v) begin
      neg <= fin_acc[ACC_W-1];
      mag <= fin_acc[ACC_W-1] ? ACC_W'(-fin_acc) : ACC_W'(fin_acc);
    end
    if (fb_v) begin
      plo <= (COEF_W+SCALE_W)'(mag[COEF_W-1:0]) * (COEF_W+SCALE_W)'(coef_scale);
    end
    if (fc_v) begin
      phi <= PROD_W'(mag[ACC_W-1:COEF_W]) * PROD_W'(coef_scale);
    end
    if (fc_v) begin
      degree_x <= tag.deg_n;
      degree_y <= tag.deg_m;
      last     <= tag.last_row;
    end
  end

  // The high partial product is registered at the same edge that raises
  // result_valid, so the output word is formed combinationally from both registered partial products.
  logic [COEF_W-1:0] coef_word;
  logic              sat_word;

  always_comb begin
    coef_word = '0;
    sat_word  = 1'b0;
    if (!neg) begin
      if (q > (COEF_W+SCALE_W)'(32'h7FFFFFFF)) begin
        coef_word = 32'h7FFFFFFF;
        sat_word  = 1'b1;
      end else begin
        coef_word = q[COEF_W-1:0];
      end
    end else begin
      if (q > (COEF_W+SCALE_W)'(32'h80000000)) begin
        coef_word = 32'h80000000;
        sat_word  = 1'b1;
      end else begin
        coef_word = COEF_W'(0) - q[COEF_W-1:0];
      end
    end
  end

  assign coefficient = coef_word;
  assign saturated   = sat_word;

  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    $onehot0({fa_v, fb_v, fc_v, result_valid}))
    else $error("more than one coefficient in the finish unit");

  a_no_mac_overlap: assert property (@(posedge clk) disable iff (rst)
    (fa_v || fb_v || fc_v) |-> !(s1.valid || s2.valid))
    else $error("accumulation ran while a coefficient was finishing");

  a_part_order: assert property (@(posedge clk) disable iff (rst)
    (s2.valid && !s2.phase2) |-> !(cmd.valid && cmd.phase2))
    else $error("partial row read before its last write");

endmodule

FILE: rtl/chebyshev_2d_projection_core.sv
// Top level of the two-dimensional Chebyshev projection core.
// Holds the configuration registers; instantiates cpj_ctrl and cpj_dp and imports cpj_pkg.
//
//  channel   direction  handshake                 payload
//  command   in         start, busy               kind, row_index, col_index, sample_value
//  result    out        result_valid (one cycle)  degree_x, degree_y, coefficient,
//                                                 saturated, last
//  config    in         cfg_valid, cfg_ready      cfg_index, cfg_data
//
// Load words are written straight into memory and busy stays low. A compute word
// for row n is paced by the single multiply-accumulate unit and its one read port
// per memory; busy stays high from its accept until its last result. Reset is
// synchronous and clears control state only, apart from loading the configuration
// defaults; the memories hold garbage until written.
// The receiver cannot stall; results leave as soon as they are ready.
module chebyshev_2d_projection_core import cpj_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [NODE_W-1:0]          row_index,
  input  logic [NODE_W-1:0]          col_index,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  output logic                       result_valid,
  output logic [DEG_W-1:0]           degree_x,
  output logic [DEG_W-1:0]           degree_y,
  output logic signed [COEF_W-1:0]   coefficient,
  output logic                       saturated,
  output logic                       last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [SCALE_W-1:0]         cfg_data
);

  logic [NCOUNT_W-1:0] node_count, nodes;
  logic [SCALE_W-1:0]  coef_scale;
  cpj_cmd_t            cmd;
  logic                load;

  assign cfg_ready = 1'b1;
  assign load      = start && !busy;
  assign nodes     = (node_count > NCOUNT_W'(MAX_NODES)) ? NCOUNT_W'(MAX_NODES) : node_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCOUNT_W'(32);
      coef_scale <= SCALE_W'(1 << 24);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODE_COUNT: node_count <= cfg_data[NCOUNT_W-1:0];
        CFG_COEF_SCALE: coef_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  cpj_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .kind         (kind),
    .row_index    (row_index),
    .nodes        (nodes),
    .result_valid (result_valid),
    .busy         (busy),
    .cmd          (cmd)
  );

  cpj_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .kind         (kind),
    .row_index    (row_index),
    .col_index    (col_index),
    .sample_value (sample_value),
    .coef_scale   (coef_scale),
    .cmd          (cmd),
    .result_valid (result_valid),
    .degree_x     (degree_x),
    .degree_y     (degree_y),
    .coefficient  (coefficient),
    .saturated    (saturated),
    .last         (last)
  );

endmodule
